/* sv/ibn_pkg.sv */
// Shared types and constants for the int8 batch normalization pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package ibn_pkg;

    localparam int SqrtSteps = 16;
    localparam int DivSteps  = 49;
    localparam int ResMax    = 127;
    localparam int ResMin    = -128;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_NORM = 1'b1
    } t_action;

    typedef struct packed {
        logic               action;
        logic signed [7:0]  sample;
        logic signed [31:0] chan_mean_in;
        logic [30:0]        chan_variance_in;
        logic signed [7:0]  chan_gamma_in;
        logic signed [7:0]  chan_beta_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] result_value;
        logic              clipped;
    } t_out_beat;

    // Per-sample coefficients that ride along with the quotient.
    typedef struct packed {
        logic              neg;
        logic signed [7:0] gamma;
        logic signed [7:0] beta;
    } t_coef;

endpackage

/* sv/ibn_sqrt.sv */
// Pipelined integer square root, one result bit per stage, in front of the datapath.
// Depends on ibn_pkg. Every beat passes through; only load beats use the root.
module ibn_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  ibn_pkg::t_in_beat i_beat,
    input  logic [15:0]       i_eps,
    output logic              o_valid,
    output ibn_pkg::t_in_beat o_beat,
    output logic [15:0]       o_root
);

    logic              r_vld  [ibn_pkg::SqrtSteps];
    ibn_pkg::t_in_beat r_beat [ibn_pkg::SqrtSteps];
    logic [31:0]       r_rem  [ibn_pkg::SqrtSteps];
    logic [31:0]       r_res  [ibn_pkg::SqrtSteps];

    for (genvar k = 0; k < ibn_pkg::SqrtSteps; k++) begin : g_step
        logic [31:0]       w_v;
        logic [31:0]       w_res;
        logic [32:0]       w_try;
        logic [31:0]       w_bit;
        logic              w_vld;
        ibn_pkg::t_in_beat w_beat;

        if (k == 0) begin : g_first
            assign w_v    = {1'b0, i_beat.chan_variance_in} + {16'd0, i_eps};
            assign w_res  = '0;
            assign w_vld  = i_valid;
            assign w_beat = i_beat;
        end else begin : g_next
            assign w_v    = r_rem[k-1];
            assign w_res  = r_res[k-1];
            assign w_vld  = r_vld[k-1];
            assign w_beat = r_beat[k-1];
        end

        assign w_bit = 32'd1 << (30 - 2 * k);
        assign w_try = {1'b0, w_res} + {1'b0, w_bit};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_beat[k] <= w_beat;
                if ({1'b0, w_v} >= w_try) begin
                    r_rem[k] <= w_v - w_try[31:0];
                    r_res[k] <= (w_res >> 1) + w_bit;
                end else begin
                    r_rem[k] <= w_v;
                    r_res[k] <= w_res >> 1;
                end
            end
        end
    end

    assign o_valid = r_vld[ibn_pkg::SqrtSteps-1];
    assign o_beat  = r_beat[ibn_pkg::SqrtSteps-1];
    assign o_root  = r_res[ibn_pkg::SqrtSteps-1][15:0];

endmodule

/* sv/ibn_div.sv */
// Pipelined restoring divider: |diff| * 65536 / d, one quotient bit per stage.
// Depends on ibn_pkg for the stage count and the coefficient struct.
module ibn_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_valid,
    input  logic signed [32:0]  i_diff,
    input  logic [15:0]         i_den,
    input  ibn_pkg::t_coef      i_coef,
    output logic                o_valid,
    output logic [48:0]         o_quot,
    output ibn_pkg::t_coef      o_coef
);

    logic           r_a_vld;
    logic [32:0]    r_a_mag;
    logic [15:0]    r_a_den;
    ibn_pkg::t_coef r_a_coef;

    logic           r_vld  [ibn_pkg::DivSteps];
    logic [48:0]    r_nq   [ibn_pkg::DivSteps];
    logic [15:0]    r_rem  [ibn_pkg::DivSteps];
    logic [15:0]    r_den  [ibn_pkg::DivSteps];
    ibn_pkg::t_coef r_coef [ibn_pkg::DivSteps];

    // Magnitude stage: the divider works on the absolute value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_adv) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_mag  <= i_diff[32] ? 33'(-i_diff) : 33'(i_diff);
            r_a_den  <= i_den;
            r_a_coef <= '{neg: i_diff[32], gamma: i_coef.gamma, beta: i_coef.beta};
        end
    end

    for (genvar k = 0; k < ibn_pkg::DivSteps; k++) begin : g_step
        logic [48:0]    w_nq;
        logic [15:0]    w_rem;
        logic [15:0]    w_den;
        ibn_pkg::t_coef w_coef;
        logic           w_vld;
        logic [16:0]    w_try;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_nq   = {r_a_mag, 16'd0};
            assign w_rem  = '0;
            assign w_den  = r_a_den;
            assign w_coef = r_a_coef;
            assign w_vld  = r_a_vld;
        end else begin : g_next
            assign w_nq   = r_nq[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_coef = r_coef[k-1];
            assign w_vld  = r_vld[k-1];
        end

        assign w_try = {w_rem, w_nq[48]};
        assign w_ge  = (w_try >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_nq[k]   <= {w_nq[47:0], w_ge};
                r_rem[k]  <= w_ge ? 16'(w_try - {1'b0, w_den}) : w_try[15:0];
                r_den[k]  <= w_den;
                r_coef[k] <= w_coef;
            end
        end
    end

    assign o_valid = r_vld[ibn_pkg::DivSteps-1];
    assign o_quot  = r_nq[ibn_pkg::DivSteps-1];
    assign o_coef  = r_coef[ibn_pkg::DivSteps-1];

endmodule

/* sv/ibn_scale.sv */
// Sign restore, gamma multiply, shift, beta add and int8 saturation.
// Depends on ibn_pkg; its last register is the block's output register.
module ibn_scale (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic [48:0]        i_quot,
    input  ibn_pkg::t_coef     i_coef,
    output logic               o_valid,
    output ibn_pkg::t_out_beat o_beat
);

    logic                r_n_vld;
    logic signed [49:0]  r_norm;
    logic signed [7:0]   r_n_gamma;
    logic signed [7:0]   r_n_beta;

    logic                r_m_vld;
    logic signed [57:0]  r_prod;
    logic signed [7:0]   r_m_beta;

    logic                r_o_vld;
    ibn_pkg::t_out_beat  r_out;

    logic signed [57:0]  w_sum;
    ibn_pkg::t_out_beat  n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (i_adv) begin
            r_n_vld <= i_valid;
            r_m_vld <= r_n_vld;
            r_o_vld <= r_m_vld;
        end
    end

    assign w_sum = (r_prod >>> 16) + 58'(r_m_beta);

    always_comb begin
        if (w_sum > 58'(ibn_pkg::ResMax)) begin
            n_out.result_value = 8'(ibn_pkg::ResMax);
            n_out.clipped      = 1'b1;
        end else if (w_sum < 58'(ibn_pkg::ResMin)) begin
            n_out.result_value = 8'(ibn_pkg::ResMin);
            n_out.clipped      = 1'b1;
        end else begin
            n_out.result_value = w_sum[7:0];
            n_out.clipped      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_norm    <= i_coef.neg ? -$signed({1'b0, i_quot}) : $signed({1'b0, i_quot});
            r_n_gamma <= i_coef.gamma;
            r_n_beta  <= i_coef.beta;
            r_prod    <= 58'(r_norm) * 58'(r_n_gamma);
            r_m_beta  <= r_n_beta;
            r_out     <= n_out;
        end
    end

    assign o_valid = r_o_vld;
    assign o_beat  = r_out;

endmodule

/* sv/int8_batch_norm.sv */
// int8 batch normalization: a fully pipelined datapath, one beat per cycle unless the output stalls.
// An accepted sample beat passes through 16 root stages, 1 parameter stage,
// 1 magnitude stage, 49 divider stages and 3 scale stages to its result beat.
// Throughput is one beat per cycle; the whole pipe advances together and freezes
// only while the output register holds a result that is not taken.
// Synchronous active-low reset clears valid bits, r_eps and the channel state.
module int8_batch_norm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ibn_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ibn_pkg::t_out_beat o_out_data
);

    // The pipe moves as one unit whenever the output register is free or drained.
    logic               w_adv;

    logic [15:0]        r_eps;

    // Channel state, written when a load beat leaves the root pipeline.
    logic [15:0]        r_std_dev;
    logic signed [31:0] r_mean;
    logic signed [7:0]  r_gamma;
    logic signed [7:0]  r_beta;

    logic               w_sq_vld;
    ibn_pkg::t_in_beat  w_sq_beat;
    logic [15:0]        w_sq_root;

    // Parameter stage: the sample meets the channel state here.
    logic               r_p_vld;
    logic signed [32:0] r_p_diff;
    logic [15:0]        r_p_den;
    ibn_pkg::t_coef     r_p_coef;

    logic               w_dv_vld;
    logic [48:0]        w_dv_quot;
    ibn_pkg::t_coef     w_dv_coef;

    logic               w_out_vld;

    assign w_adv      = !w_out_vld || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    ibn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_beat  (i_in_data),
        .i_eps   (r_eps),
        .o_valid (w_sq_vld),
        .o_beat  (w_sq_beat),
        .o_root  (w_sq_root)
    );

    // A load beat updates the channel state and ends here with no result. A sample
    // beat one slot behind it sees the new state, since the state is written before that beat reads it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_std_dev <= '0;
            r_mean    <= '0;
            r_gamma   <= '0;
            r_beta    <= '0;
            r_p_vld   <= 1'b0;
        end else if (w_adv) begin
            r_p_vld <= w_sq_vld && (w_sq_beat.action == ibn_pkg::ACT_NORM);
            if (w_sq_vld && (w_sq_beat.action == ibn_pkg::ACT_LOAD)) begin
                r_std_dev <= w_sq_root;
                r_mean    <= w_sq_beat.chan_mean_in;
                r_gamma   <= w_sq_beat.chan_gamma_in;
                r_beta    <= w_sq_beat.chan_beta_in;
            end
        end
    end

    // A zero root is replaced by one so the divider never sees a zero divisor.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_diff       <= 33'(w_sq_beat.sample) - 33'(r_mean);
            r_p_den        <= (r_std_dev == 16'd0) ? 16'd1 : r_std_dev;
            r_p_coef.neg   <= 1'b0;
            r_p_coef.gamma <= r_gamma;
            r_p_coef.beta  <= r_beta;
        end
    end

    ibn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_p_vld),
        .i_diff  (r_p_diff),
        .i_den   (r_p_den),
        .i_coef  (r_p_coef),
        .o_valid (w_dv_vld),
        .o_quot  (w_dv_quot),
        .o_coef  (w_dv_coef)
    );

    ibn_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_dv_vld),
        .i_quot  (w_dv_quot),
        .i_coef  (w_dv_coef),
        .o_valid (w_out_vld),
        .o_beat  (o_out_data)
    );

    assign o_out_valid = w_out_vld;

endmodule
